// ===== rtl/core/lsl_pkg.sv =====
package lsl_pkg;

	// field widths
	localparam int COUNT_W = 16;
	localparam int LUX_W   = 40;
	localparam int ATIME_W = 10;
	localparam int AGAIN_W = 14;
	localparam int DF_W    = 12;
	localparam int NUM_W   = 52;
	localparam int DEN_W   = 39;
	localparam int DIV_BITS = 40;

	// accept-to-strobe latency: three front stages, overflow check, divider steps, output
	localparam int LATENCY = 3 + 1 + DIV_BITS + 1;

	localparam logic [COUNT_W-1:0] SAT_COUNT = 16'hFFFF;
	localparam logic [LUX_W-1:0]   LUX_MAX   = {LUX_W{1'b1}};

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CH_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO    = 2'd2;
	localparam logic [1:0] ST_RES_SAT = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ITIME = 2'd0;
	localparam logic [1:0] CFG_GAIN  = 2'd1;
	localparam logic [1:0] CFG_DF    = 2'd2;

	localparam logic [2:0]      ITIME_RST = 3'd0;
	localparam logic [1:0]      GAIN_RST  = 2'd1;
	localparam logic [DF_W-1:0] DF_RST    = 12'd408;

	typedef struct packed {
		logic [COUNT_W-1:0] full_count;
		logic [COUNT_W-1:0] ir_count;
	} sample_t;

	typedef struct packed {
		logic [LUX_W-1:0] lux_q8;
		logic [1:0]       status;
	} result_t;

	// front end to divider
	typedef struct packed {
		logic [1:0]       status;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} frac_t;

	// one divider step's payload
	typedef struct packed {
		logic [1:0]          status;
		logic [DEN_W-1:0]    den;
		logic [DEN_W-1:0]    rem;
		logic [DIV_BITS-1:0] nq;
	} div_st_t;

	function automatic logic [ATIME_W-1:0] atime_ms(input logic [2:0] code);
		logic [ATIME_W-1:0] r;
		unique case (code)
			3'd1: r = 10'd200;
			3'd2: r = 10'd300;
			3'd3: r = 10'd400;
			3'd4: r = 10'd500;
			3'd5: r = 10'd600;
			default: r = 10'd100;
		endcase
		return r;
	endfunction

	function automatic logic [AGAIN_W-1:0] again_x(input logic [1:0] code);
		logic [AGAIN_W-1:0] r;
		unique case (code)
			2'd0: r = 14'd1;
			2'd1: r = 14'd25;
			2'd2: r = 14'd428;
			default: r = 14'd9876;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/lsl_front.sv =====
module lsl_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  lsl_pkg::sample_t             sample,
	input  logic [2:0]                   integration_code,
	input  logic [1:0]                   gain_code,
	input  logic [lsl_pkg::DF_W-1:0]     lux_df,
	output logic                         out_valid,
	output lsl_pkg::frac_t               frac
);

	logic                          valid_s1, valid_s2, valid_s3;
	logic [1:0]                    status_s1, status_s2, status_s3;
	logic [lsl_pkg::COUNT_W-1:0]   diff_s1, full_s1;
	logic [lsl_pkg::ATIME_W-1:0]   atime_s1;
	logic [lsl_pkg::AGAIN_W-1:0]   again_s1, again_s2;
	logic [lsl_pkg::DF_W-1:0]      df_s1, df_s2;
	logic [2*lsl_pkg::COUNT_W-1:0] sq_s2;
	logic [lsl_pkg::COUNT_W+lsl_pkg::ATIME_W-1:0] fa_s2;
	logic [lsl_pkg::NUM_W-1:0]     num_s3;
	logic [lsl_pkg::DEN_W-1:0]     den_s3;

	logic [1:0]                    status_in;
	logic [lsl_pkg::COUNT_W-1:0]   diff_in;
	logic [43:0]                   sqdf;
	logic [39:0]                   den_full;

	always_comb begin
		priority if (sample.full_count == lsl_pkg::SAT_COUNT
				|| sample.ir_count == lsl_pkg::SAT_COUNT) begin
			status_in = lsl_pkg::ST_CH_SAT;
		end else if (sample.full_count == '0) begin
			status_in = lsl_pkg::ST_ZERO;
		end else begin
			status_in = lsl_pkg::ST_OK;
		end
		if (sample.full_count >= sample.ir_count) begin
			diff_in = sample.full_count - sample.ir_count;
		end else begin
			diff_in = sample.ir_count - sample.full_count;
		end
	end

	assign sqdf     = 44'(sq_s2) * 44'(df_s2);
	assign den_full = 40'(fa_s2) * 40'(again_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= status_in;
		diff_s1   <= diff_in;
		full_s1   <= sample.full_count;
		atime_s1  <= lsl_pkg::atime_ms(integration_code);
		again_s1  <= lsl_pkg::again_x(gain_code);
		df_s1     <= lux_df;

		status_s2 <= status_s1;
		sq_s2     <= 32'(diff_s1) * 32'(diff_s1);
		fa_s2     <= 26'(full_s1) * 26'(atime_s1);
		again_s2  <= again_s1;
		df_s2     <= df_s1;

		status_s3 <= status_s2;
		num_s3    <= {sqdf, 8'd0};
		den_s3    <= den_full[lsl_pkg::DEN_W-1:0];
	end

	assign out_valid   = valid_s3;
	assign frac.status = status_s3;
	assign frac.num    = num_s3;
	assign frac.den    = den_s3;

endmodule

// ===== rtl/core/lsl_div_step.sv =====
module lsl_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lsl_pkg::div_st_t  in_st,
	output logic              out_valid,
	output lsl_pkg::div_st_t  out_st
);

	logic [lsl_pkg::DEN_W:0] trial;
	logic                    ge;
	logic [lsl_pkg::DEN_W:0] diff;
	logic                    valid_s;
	lsl_pkg::div_st_t        st_s;

	// shift in next numerator bit, subtract when it fits
	assign trial = {in_st.rem, in_st.nq[lsl_pkg::DIV_BITS-1]};
	assign ge    = trial >= {1'b0, in_st.den};
	assign diff  = trial - {1'b0, in_st.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		st_s.status <= in_st.status;
		st_s.den    <= in_st.den;
		st_s.rem    <= ge ? diff[lsl_pkg::DEN_W-1:0] : trial[lsl_pkg::DEN_W-1:0];
		st_s.nq     <= {in_st.nq[lsl_pkg::DIV_BITS-2:0], ge};
	end

	assign out_valid = valid_s;
	assign out_st    = st_s;

endmodule

// ===== rtl/core/lsl_divider.sv =====
module lsl_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lsl_pkg::frac_t    frac,
	output logic              done,
	output lsl_pkg::result_t  result
);

	localparam int N = lsl_pkg::DIV_BITS;

	logic              valid_s4;
	lsl_pkg::div_st_t  st_s4;
	logic              v [0:N];
	lsl_pkg::div_st_t  st [0:N];
	logic              ovf;
	logic              done_q;
	lsl_pkg::result_t  result_q;

	// quotient exceeds 40 bits when the top numerator bits reach the divisor
	assign ovf = {{(lsl_pkg::DEN_W-(lsl_pkg::NUM_W-N)){1'b0}}, frac.num[lsl_pkg::NUM_W-1:N]}
		>= frac.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			done_q   <= v[N];
		end
	end

	always_ff @(posedge clk) begin
		st_s4.den <= frac.den;
		st_s4.nq  <= frac.num[N-1:0];
		if (frac.status == lsl_pkg::ST_OK && !ovf) begin
			st_s4.status <= lsl_pkg::ST_OK;
			st_s4.rem    <= lsl_pkg::DEN_W'(frac.num[lsl_pkg::NUM_W-1:N]);
		end else begin
			st_s4.status <= (frac.status == lsl_pkg::ST_OK) ? lsl_pkg::ST_RES_SAT : frac.status;
			st_s4.rem    <= '0;
		end
	end

	assign v[0]  = valid_s4;
	assign st[0] = st_s4;

	for (genvar i = 0; i < N; i++) begin : g_step
		lsl_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_st     (st[i]),
			.out_valid (v[i+1]),
			.out_st    (st[i+1])
		);
	end

	always_ff @(posedge clk) begin
		result_q.status <= st[N].status;
		unique case (st[N].status)
			lsl_pkg::ST_OK:      result_q.lux_q8 <= st[N].nq;
			lsl_pkg::ST_RES_SAT: result_q.lux_q8 <= lsl_pkg::LUX_MAX;
			default:             result_q.lux_q8 <= '0;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && st_s4.status == lsl_pkg::ST_OK |-> st_s4.rem < st_s4.den)
		else $error("divider start remainder not below divisor");

endmodule

// ===== rtl/core/light_sensor_lux_calc.sv =====
// channel   signals                          width  notes
// -------   -------------------------------  -----  ---------------------------------
// input     start, busy, sample              1/1/32 item taken when start && !busy
// result    done, result                     1/42   one-cycle strobe, no back pressure
// config    cfg_we, cfg_index, cfg_data      1/2/12 0 itime, 1 gain, 2 lux_df
//
// one item per cycle; result strobes after the front stages, overflow check, divider steps and output register
// the 40-step restoring divider computes one quotient bit per stage
// busy is always low: the pipeline never stalls, results cannot be held off
// arst_n clears valid bits and loads config registers with defaults; data registers are not reset
module light_sensor_lux_calc (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  lsl_pkg::sample_t         sample,
	output logic                     done,
	output lsl_pkg::result_t         result,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [lsl_pkg::DF_W-1:0] cfg_data
);

	// configuration registers
	logic [2:0]               itime_q;
	logic [1:0]               gain_q;
	logic [lsl_pkg::DF_W-1:0] df_q;

	// front end to divider
	logic            frac_valid;
	lsl_pkg::frac_t  frac;
	logic            accept;

	// no back pressure anywhere, so the block is always ready
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// index 3 is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itime_q <= lsl_pkg::ITIME_RST;
			gain_q  <= lsl_pkg::GAIN_RST;
			df_q    <= lsl_pkg::DF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsl_pkg::CFG_ITIME: itime_q <= cfg_data[2:0];
				lsl_pkg::CFG_GAIN:  gain_q  <= cfg_data[1:0];
				lsl_pkg::CFG_DF:    df_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stages 1-3: |full-ir|, squares and products, numerator and divisor
	lsl_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (accept),
		.sample           (sample),
		.integration_code (itime_q),
		.gain_code        (gain_q),
		.lux_df           (df_q),
		.out_valid        (frac_valid),
		.frac             (frac)
	);

	// stage 4 overflow check, 40 divide steps, output register
	lsl_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frac_valid),
		.frac     (frac),
		.done     (done),
		.result   (result)
	);

	// every accepted item comes out on done, at the delay given by lsl_pkg::LATENCY
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(lsl_pkg::LATENCY) done)
		else $error("item did not complete at the expected cycle");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == lsl_pkg::ST_RES_SAT |-> result.lux_q8 == lsl_pkg::LUX_MAX)
		else $error("saturated result without full-scale lux");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == lsl_pkg::ST_CH_SAT || result.status == lsl_pkg::ST_ZERO)
		|-> result.lux_q8 == '0)
		else $error("fault status with nonzero lux");

endmodule
